// ----- design/llt_pkg.sv -----
`default_nettype none

package llt_pkg;

	// Table geometry
	localparam int ENTRIES = 128;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int LINK_W  = $clog2(ENTRIES + 1);

	// Word field widths
	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 7;

	// Link code that marks the end of a chain
	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	// Table read address source
	typedef enum logic [1:0] {
		RD_CUR  = 2'd0,
		RD_FREE = 2'd1,
		RD_HEAD = 2'd2,
		RD_NEXT = 2'd3
	} rd_sel_t;

	// Result index source
	typedef enum logic [1:0] {
		IX_ZERO = 2'd0,
		IX_FREE = 2'd1,
		IX_CUR  = 2'd2
	} ix_sel_t;

	typedef enum logic [2:0] {
		S_CLEAR    = 3'd0,
		S_IDLE     = 3'd1,
		S_DISPATCH = 3'd2,
		S_INS_WR   = 3'd3,
		S_WALK     = 3'd4,
		S_DEL_LINK = 3'd5,
		S_DEL_FREE = 3'd6,
		S_RESULT   = 3'd7
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic    clr_step;
		logic    req_take;
		logic    walk_init;
		logic    walk_adv;
		logic    ins_wr;
		logic    del_link;
		logic    del_free;
		logic    res_set;
		status_t res_status;
		ix_sel_t res_ix;
		rd_sel_t rd_sel;
		logic    out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic                clr_last;
		logic [OPCODE_W-1:0] opcode;
		logic                free_nil;
		logic                head_nil;
		logic                match;
		logic                walk_end;
		logic                out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/llt_req_if.sv -----
`default_nettype none

interface llt_req_if;
	import llt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ----- design/llt_rsp_if.sv -----
`default_nettype none

interface llt_rsp_if;
	import llt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  entry_index;

	modport source (output valid, output status, output entry_index, input ready);
	modport sink   (input valid, input status, input entry_index, output ready);
endinterface

`default_nettype wire

// ----- design/llt_ram.sv -----
`default_nettype none

module llt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/llt_datapath.sv -----
`default_nettype none

module llt_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire llt_pkg::cmd_t                       cmd,
	output llt_pkg::sts_t                            sts,
	input  wire logic [llt_pkg::OPCODE_W-1:0]        req_opcode,
	input  wire logic signed [llt_pkg::VALUE_W-1:0]  req_value,
	input  wire logic                                rsp_ready,
	output logic                                     rsp_valid,
	output logic [llt_pkg::STATUS_W-1:0]             rsp_status,
	output logic [llt_pkg::INDEX_W-1:0]              rsp_entry_index
);
	import llt_pkg::*;

	logic [OPCODE_W-1:0] op_q;
	logic [VALUE_W-1:0]  value_q;
	logic [LINK_W-1:0]   list_head_q;
	logic [LINK_W-1:0]   free_head_q;
	logic [LINK_W-1:0]   cur_q;
	logic [LINK_W-1:0]   prev_q;
	logic [LINK_W-1:0]   steps_q;
	logic [IDX_W-1:0]    clr_cnt_q;
	status_t             res_status_q;
	logic [INDEX_W-1:0]  res_index_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [INDEX_W-1:0]  out_index_q;

	logic                raddr_we_unused;
	logic [IDX_W-1:0]    raddr;
	logic                val_we;
	logic [IDX_W-1:0]    val_waddr;
	logic [VALUE_W-1:0]  val_wdata;
	logic [VALUE_W-1:0]  val_rdata;
	logic                link_we;
	logic [IDX_W-1:0]    link_waddr;
	logic [LINK_W-1:0]   link_wdata;
	logic [LINK_W-1:0]   link_rdata;
	logic                prev_nil;

	assign raddr_we_unused = 1'b0;
	assign prev_nil = !(prev_q < NIL_LINK);

	// Pick the entry to read for the next cycle
	always_comb begin
		unique case (cmd.rd_sel)
			RD_CUR:  raddr = cur_q[IDX_W-1:0];
			RD_FREE: raddr = free_head_q[IDX_W-1:0];
			RD_HEAD: raddr = list_head_q[IDX_W-1:0];
			RD_NEXT: raddr = link_rdata[IDX_W-1:0];
		endcase
	end

	// Value table write: insert only
	assign val_we    = cmd.ins_wr;
	assign val_waddr = free_head_q[IDX_W-1:0];
	assign val_wdata = value_q;

	// Link table write: clearing pass, insert, unlink, free
	always_comb begin
		link_we    = 1'b0;
		link_waddr = cur_q[IDX_W-1:0];
		link_wdata = free_head_q;
		if (cmd.clr_step) begin
			link_we    = 1'b1;
			link_waddr = clr_cnt_q;
			link_wdata = LINK_W'(clr_cnt_q) + LINK_W'(1);
		end else if (cmd.ins_wr) begin
			link_we    = 1'b1;
			link_waddr = free_head_q[IDX_W-1:0];
			link_wdata = list_head_q;
		end else if (cmd.del_link && !prev_nil) begin
			link_we    = 1'b1;
			link_waddr = prev_q[IDX_W-1:0];
			link_wdata = link_rdata;
		end else if (cmd.del_free) begin
			link_we    = 1'b1;
			link_waddr = cur_q[IDX_W-1:0];
			link_wdata = free_head_q;
		end
	end

	llt_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (ENTRIES)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we | raddr_we_unused),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (raddr),
		.rdata (val_rdata)
	);

	llt_ram #(
		.WIDTH (LINK_W),
		.DEPTH (ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (raddr),
		.rdata (link_rdata)
	);

	// Report status to the controller
	always_comb begin
		sts          = '0;
		sts.clr_last = (clr_cnt_q == IDX_W'(ENTRIES - 1));
		sts.opcode   = op_q;
		sts.free_nil = !(free_head_q < NIL_LINK);
		sts.head_nil = !(list_head_q < NIL_LINK);
		sts.match    = (val_rdata == value_q);
		sts.walk_end = (steps_q == LINK_W'(ENTRIES - 1)) || !(link_rdata < NIL_LINK);
		sts.out_free = !out_valid_q || rsp_ready;
	end

	// Hold list heads, clearing counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q <= NIL_LINK;
			free_head_q <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			end
			if (cmd.ins_wr) begin
				free_head_q <= link_rdata;
				list_head_q <= free_head_q;
			end
			if (cmd.del_link && prev_nil) begin
				list_head_q <= link_rdata;
			end
			if (cmd.del_free) begin
				free_head_q <= cur_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, walk cursor and result payload
	always_ff @(posedge clk) begin
		if (cmd.req_take) begin
			op_q    <= req_opcode;
			value_q <= $unsigned(req_value);
		end
		if (cmd.walk_init) begin
			cur_q   <= list_head_q;
			prev_q  <= NIL_LINK;
			steps_q <= '0;
		end else if (cmd.walk_adv) begin
			prev_q  <= cur_q;
			cur_q   <= link_rdata;
			steps_q <= steps_q + LINK_W'(1);
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			unique case (cmd.res_ix)
				IX_FREE: res_index_q <= INDEX_W'(free_head_q);
				IX_CUR:  res_index_q <= INDEX_W'(cur_q);
				default: res_index_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_status      = out_status_q;
	assign rsp_entry_index = out_index_q;

endmodule

`default_nettype wire

// ----- design/llt_ctrl.sv -----
`default_nettype none

module llt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire llt_pkg::sts_t sts,
	output llt_pkg::cmd_t      cmd,
	input  wire logic          req_valid,
	output logic               req_ready
);
	import llt_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_CUR;
		req_ready  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.req_take = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (op_t'(sts.opcode))
					OP_INSERT: begin
						if (sts.free_nil) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = STAT_FULL;
							cmd.res_ix     = IX_ZERO;
							state_d        = S_RESULT;
						end else begin
							cmd.rd_sel = RD_FREE;
							state_d    = S_INS_WR;
						end
					end
					OP_DELETE, OP_SEARCH: begin
						cmd.walk_init = 1'b1;
						if (sts.head_nil) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = STAT_NOT_FOUND;
							cmd.res_ix     = IX_ZERO;
							state_d        = S_RESULT;
						end else begin
							cmd.rd_sel = RD_HEAD;
							state_d    = S_WALK;
						end
					end
					default: begin
						// unused opcode: no change, plain success
						cmd.res_set    = 1'b1;
						cmd.res_status = STAT_OK;
						cmd.res_ix     = IX_ZERO;
						state_d        = S_RESULT;
					end
				endcase
			end
			S_INS_WR: begin
				cmd.ins_wr     = 1'b1;
				cmd.res_set    = 1'b1;
				cmd.res_status = STAT_OK;
				cmd.res_ix     = IX_FREE;
				state_d        = S_RESULT;
			end
			S_WALK: begin
				if (sts.match) begin
					if (sts.opcode == OP_SEARCH) begin
						cmd.res_set    = 1'b1;
						cmd.res_status = STAT_OK;
						cmd.res_ix     = IX_CUR;
						state_d        = S_RESULT;
					end else begin
						state_d = S_DEL_LINK;
					end
				end else if (sts.walk_end) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STAT_NOT_FOUND;
					cmd.res_ix     = IX_ZERO;
					state_d        = S_RESULT;
				end else begin
					cmd.walk_adv = 1'b1;
					cmd.rd_sel   = RD_NEXT;
				end
			end
			S_DEL_LINK: begin
				cmd.del_link = 1'b1;
				state_d      = S_DEL_FREE;
			end
			S_DEL_FREE: begin
				cmd.del_free   = 1'b1;
				cmd.res_set    = 1'b1;
				cmd.res_status = STAT_OK;
				cmd.res_ix     = IX_ZERO;
				state_d        = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/linked_list_in_table_unit.sv -----
`default_nettype none

// Channel  Dir  Fields               Notes
// req      in   opcode, value        request word, taken when valid and ready
// rsp      out  status, entry_index  one result word per request, registered
//
// Insert and unused opcodes are dispatched, an insert with a free entry writes
// both tables, and the result is then loaded into the output register. Delete
// and search walk one entry per cycle through the value and link tables, up to ENTRIES entries; a delete that hits
// then unlinks the entry and frees it. After reset a clearing pass writes every link table entry, req.ready low.
// A result waits in the output register; one more word is taken meanwhile and
// its result is held in the datapath until the output register is free.

module linked_list_in_table_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	llt_req_if.sink    req,
	llt_rsp_if.source  rsp
);
	import llt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	llt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.cmd       (cmd),
		.req_valid (req.valid),
		.req_ready (req.ready)
	);

	llt_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_opcode      (req.opcode),
		.req_value       (req.value),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_entry_index (rsp.entry_index)
	);

endmodule

`default_nettype wire

// ----- design/llt_checker.sv -----
`default_nettype none

module llt_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	input  wire logic                         req_ready,
	input  wire logic                         rsp_valid,
	input  wire logic                         rsp_ready,
	input  wire logic [llt_pkg::STATUS_W-1:0] rsp_status,
	input  wire logic [llt_pkg::INDEX_W-1:0]  rsp_entry_index
);
	import llt_pkg::*;

	logic [1:0] pend_q;

	// Count words taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_status) && $stable(rsp_entry_index))
		else $error("result word changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result word without a request");

	a_ready_bound: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> pend_q <= 2'd1)
		else $error("request taken with two words outstanding");

	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_OK |-> rsp_entry_index == '0)
		else $error("failed request carries a non-zero index");

endmodule

bind linked_list_in_table_unit llt_checker u_llt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_index (rsp.entry_index)
);

`default_nettype wire

// ----- bench/llt_list_checker.sv -----
`default_nettype none

module llt_list_checker
	import llt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	llt_req_if        req,
	llt_rsp_if        rsp,
	output int        fail_count,
	output int        words_owed,
	output int        results_seen,
	output int        full_count,
	output int        miss_count,
	output int        peak_len
);

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] entry_index;
	} list_result_t;

	// Own copy of the table, the list and the free list
	logic [VALUE_W-1:0] vals  [ENTRIES];
	logic [LINK_W-1:0]  links [ENTRIES];
	logic [LINK_W-1:0]  list_top;
	logic [LINK_W-1:0]  spare_top;
	int                 list_len;
	int                 n_fail, n_seen, n_full, n_miss, n_peak;
	list_result_t       owed_results [$];

	// Walk from the list head to the first entry holding v, at most ENTRIES steps
	function automatic bit find_first(input logic [VALUE_W-1:0] v,
		output logic [LINK_W-1:0] hit, output logic [LINK_W-1:0] hit_prev);
		logic [LINK_W-1:0] cur, prv;
		cur      = list_top;
		prv      = NIL_LINK;
		hit      = NIL_LINK;
		hit_prev = NIL_LINK;
		for (int n = 0; n < ENTRIES && cur < ENTRIES; n++) begin
			if (vals[cur[IDX_W-1:0]] == v) begin
				hit      = cur;
				hit_prev = prv;
				return 1'b1;
			end
			prv = cur;
			cur = links[cur[IDX_W-1:0]];
		end
		return 1'b0;
	endfunction

	// Apply one request word to the table copy and work out its result
	function automatic list_result_t apply_request(input logic [OPCODE_W-1:0] op,
		input logic [VALUE_W-1:0] v);
		list_result_t      res;
		logic [LINK_W-1:0] hit, hit_prev, slot;
		bit                found;
		res.status      = STAT_OK;
		res.entry_index = '0;
		case (op)
		OP_INSERT: begin
			if (spare_top >= ENTRIES) begin
				res.status = STAT_FULL;
			end else begin
				slot                  = spare_top;
				spare_top             = links[slot[IDX_W-1:0]];
				vals[slot[IDX_W-1:0]]  = v;
				links[slot[IDX_W-1:0]] = list_top;
				list_top              = slot;
				res.entry_index       = slot[INDEX_W-1:0];
				list_len++;
			end
		end
		OP_DELETE: begin
			found = find_first(v, hit, hit_prev);
			if (found) begin
				if (hit_prev != NIL_LINK)
					links[hit_prev[IDX_W-1:0]] = links[hit[IDX_W-1:0]];
				else
					list_top = links[hit[IDX_W-1:0]];
				links[hit[IDX_W-1:0]] = spare_top;
				spare_top            = hit;
				list_len--;
			end else begin
				res.status = STAT_NOT_FOUND;
			end
		end
		OP_SEARCH: begin
			found = find_first(v, hit, hit_prev);
			if (found)
				res.entry_index = hit[INDEX_W-1:0];
			else
				res.status = STAT_NOT_FOUND;
		end
		default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track_words
		list_result_t want;
		if (!arst_n) begin
			// Rebuild the free list over every entry, list empty
			for (int i = 0; i < ENTRIES; i++) begin
				vals[i]  = '0;
				links[i] = LINK_W'(i + 1);
			end
			list_top  = NIL_LINK;
			spare_top = '0;
			list_len  = 0;
			n_fail    = 0;
			n_seen    = 0;
			n_full    = 0;
			n_miss    = 0;
			n_peak    = 0;
			owed_results.delete();
		end else begin
			// Compare a returned word with the oldest result owed
			if (rsp.valid && rsp.ready) begin
				n_seen++;
				if (owed_results.size() == 0) begin
					if (n_fail < REPORT_MAX)
						$display("%0t: result word with none owed: status %0d index %0d",
							$realtime, rsp.status, rsp.entry_index);
					n_fail++;
				end else begin
					want = owed_results.pop_front();
					if (rsp.status !== want.status || rsp.entry_index !== want.entry_index) begin
						if (n_fail < REPORT_MAX)
							$display("%0t: result %0d wrong: status %0d want %0d, index %0d want %0d",
								$realtime, n_seen, rsp.status, want.status,
								rsp.entry_index, want.entry_index);
						n_fail++;
					end
				end
			end
			// Predict the result of an accepted request word
			if (req.valid && req.ready) begin
				want = apply_request(req.opcode, req.value);
				owed_results.push_back(want);
				if (want.status == STAT_FULL)
					n_full++;
				if (want.status == STAT_NOT_FOUND)
					n_miss++;
				if (list_len > n_peak)
					n_peak = list_len;
			end
		end
		fail_count   <= n_fail;
		words_owed   <= owed_results.size();
		results_seen <= n_seen;
		full_count   <= n_full;
		miss_count   <= n_miss;
		peak_len     <= n_peak;
	end

endmodule

`default_nettype wire

// ----- bench/tb_linked_list_in_table_unit.sv -----
`default_nettype none

module tb_linked_list_in_table_unit;
	import llt_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1700;
	localparam int KEY_COUNT    = 16;

	typedef enum int {PACE_FREE, PACE_COIN, PACE_THIRD, PACE_SLOW} pace_t;

	logic clk = 1'b0;
	logic arst_n;

	llt_req_if req_ch ();
	llt_rsp_if rsp_ch ();

	int fail_count, words_owed, results_seen, full_count, miss_count, peak_len;
	int words_sent, burst_left;

	// Small key pool so that deletes and searches hit, plus values of a fill
	logic [VALUE_W-1:0] keys [KEY_COUNT];
	logic [VALUE_W-1:0] stacked [$];

	always #5 clk = ~clk;

	linked_list_in_table_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	llt_list_checker i_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.words_owed   (words_owed),
		.results_seen (results_seen),
		.full_count   (full_count),
		.miss_count   (miss_count),
		.peak_len     (peak_len)
	);

	initial begin : watchdog
		#30_000_000;
		$display("status: fail");
		$finish;
	end

	// Stall the result side on a randomly chosen pattern that is redrawn when its run ends
	initial begin : rsp_pace
		pace_t pace;
		int    left;
		rsp_ch.ready <= 1'b0;
		pace = PACE_FREE;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				pace = pace_t'($urandom_range(0, 3));
				left = $urandom_range(16, 256);
			end
			left--;
			case (pace)
			PACE_FREE:  rsp_ch.ready <= 1'b1;
			PACE_COIN:  rsp_ch.ready <= 1'($urandom_range(0, 1));
			PACE_THIRD: rsp_ch.ready <= (left % 3 != 0);
			default:    rsp_ch.ready <= (left % 13 == 0);
			endcase
		end
	end

	task automatic refresh_keys();
		for (int i = 0; i < KEY_COUNT; i++)
			keys[i] = $urandom;
	endtask

	// Mostly pool keys, some corner values, the rest fully random
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return keys[$urandom_range(0, KEY_COUNT - 1)];
		if (r < 76) begin
			case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// Offer one word, hold it until taken, then at the end of a burst sometimes idle
	task automatic push_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v);
		int gap;
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.value  <= v;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and hold until every owed result has come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (words_owed != 0);
	endtask

	task automatic run_mixed(input int count);
		int ins_pct, r;
		ins_pct = $urandom_range(20, 60);
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				push_word(OP_INSERT, pick_value());
			else if (r < 95 && $urandom_range(0, 1) == 1)
				push_word(OP_DELETE, pick_value());
			else if (r < 95)
				push_word(OP_SEARCH, pick_value());
			else
				push_word(OP_UNUSED, $urandom);
		end
	endtask

	// Fill past full, look around in the full table, then delete all that went in
	task automatic run_fill_drain();
		logic [VALUE_W-1:0] v;
		int                 k;
		stacked.delete();
		repeat (ENTRIES + 12) begin
			v = pick_value();
			stacked.push_back(v);
			push_word(OP_INSERT, v);
		end
		repeat (24) begin
			if ($urandom_range(0, 1) == 1)
				push_word(OP_SEARCH, pick_value());
			else
				push_word(OP_DELETE, pick_value());
		end
		while (stacked.size() > 0) begin
			k = $urandom_range(0, stacked.size() - 1);
			v = stacked[k];
			stacked.delete(k);
			push_word(OP_DELETE, v);
		end
	endtask

	initial begin : stimulus
		int phase, stop_at;
		arst_n        <= 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.opcode <= OP_INSERT;
		req_ch.value  <= '0;
		words_sent = 0;
		burst_left = 0;
		refresh_keys();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty list, unused opcode, corner values, duplicates, head/middle/tail deletes
		push_word(OP_SEARCH, 32'h0000_0000);
		push_word(OP_DELETE, 32'h0000_0000);
		push_word(OP_UNUSED, 32'h1234_5678);
		push_word(OP_INSERT, 32'h8000_0000);
		push_word(OP_INSERT, 32'h7FFF_FFFF);
		push_word(OP_INSERT, 32'h0000_0000);
		push_word(OP_INSERT, 32'hFFFF_FFFF);
		push_word(OP_INSERT, 32'hAAAA_AAAA);
		push_word(OP_INSERT, 32'h5555_5555);
		push_word(OP_INSERT, 32'hAAAA_AAAA);
		push_word(OP_SEARCH, 32'h8000_0000);
		push_word(OP_SEARCH, 32'h7FFF_FFFF);
		push_word(OP_SEARCH, 32'hAAAA_AAAA);
		push_word(OP_SEARCH, 32'h1234_5678);
		push_word(OP_DELETE, 32'hAAAA_AAAA);
		push_word(OP_SEARCH, 32'hAAAA_AAAA);
		push_word(OP_DELETE, 32'h8000_0000);
		push_word(OP_DELETE, 32'h0000_0000);
		push_word(OP_DELETE, 32'h1234_5678);
		push_word(OP_UNUSED, 32'hFFFF_FFFF);
		push_word(OP_SEARCH, 32'hFFFF_FFFF);
		settle();

		// Random phases, starting with one full fill and drain
		stop_at = words_sent + RANDOM_WORDS;
		run_fill_drain();
		while (words_sent < stop_at) begin
			phase = $urandom_range(0, 9);
			if (phase < 6) begin
				run_mixed($urandom_range(20, 120));
			end else if (phase < 7) begin
				run_fill_drain();
			end else if (phase < 9) begin
				repeat ($urandom_range(10, 40)) begin
					if ($urandom_range(0, 1) == 1)
						push_word(OP_SEARCH, $urandom);
					else
						push_word(OP_DELETE, $urandom);
				end
			end else begin
				settle();
				refresh_keys();
			end
		end

		settle();
		repeat (ENTRIES + 16) @(posedge clk);
		$display("covered %0d request words, %0d results: %0d on a full table, %0d not found",
			words_sent, results_seen, full_count, miss_count);
		$display("list reached %0d of %0d entries", peak_len, ENTRIES);
		if (fail_count == 0 && words_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
design/llt_pkg.sv
design/llt_req_if.sv
design/llt_rsp_if.sv
design/llt_ram.sv
design/llt_datapath.sv
design/llt_ctrl.sv
design/linked_list_in_table_unit.sv
design/llt_checker.sv
bench/llt_list_checker.sv
bench/tb_linked_list_in_table_unit.sv
